[sv/bsoc_pkg.sv]
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared types and constants for the battery state-of-charge estimator:
// queue entry, back-end state encoding, register indexes and the Li-ion curve.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  // Field widths
  localparam int ADC_W   = 12;  // converter reading
  localparam int RATIO_W = 3;   // divider ratio register
  localparam int SHIFT_W = 3;   // smoothing shift register
  localparam int MV_W    = 14;  // battery millivolts / average
  localparam int PCT_W   = 7;   // charge percentage
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;

  // Stream data widths (padded to whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_SHIFT = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 3'd2;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;

  localparam logic [MV_W-1:0] MV_MAX = 14'd16383;

  // Discharge curve, highest voltage first
  localparam int CURVE_POINTS = 11;
  localparam int SEG_W  = 4;        // segment index
  localparam int CMV_W  = 13;       // curve voltage width
  localparam int SPAN_W = 9;        // widest segment is 380 mV
  localparam int DP_W   = 4;        // percent step per segment
  localparam int NUM_W  = SPAN_W + DP_W;
  localparam int CNT_W  = 4;        // divider step counter

  localparam logic [CMV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd4200, 13'd4060, 13'd3980, 13'd3920, 13'd3870, 13'd3820,
    13'd3790, 13'd3770, 13'd3730, 13'd3680, 13'd3300
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
  };
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  // Item passed from the front end to the back end
  typedef struct packed {
    logic            read_ok;
    logic [MV_W-1:0] volt;     // scaled and saturated battery voltage
  } bsoc_entry_t;

  // Back-end sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOKUP,
    B_DIV,
    B_EMIT
  } bsoc_state_t;

endpackage

[sv/battery_ema_soc_estimator.sv]
// ----------------------------------------------------------------------------
// battery_ema_soc_estimator
// Battery voltage smoothing and state-of-charge estimate from ADC samples.
// ----------------------------------------------------------------------------
// Each accepted sample returns one result: the charge percentage, the smoothed
// battery voltage and a sample-seen flag. A good sample goes through queue pop,
// average update, curve lookup, a 13-step serial divide for the interpolation
// and result load; a sample on or beyond a curve end skips the divide, and a
// failed read goes from the pop to the load. The back end takes no new sample
// until the last result is loaded, so the serial divider limits the sustained
// rate. A queue of QUEUE_DEPTH entries in front of the sequencer keeps the input
// ready, until it fills, while a result waits to be taken. The user must write
// configuration registers only while the block is idle; it does not enforce this.
module battery_ema_soc_estimator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Sample stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [bsoc_pkg::IN_TDATA_W-1:0]        in_tdata,   // [11:0] adc_millivolts
  input  logic                                   in_tuser,   // [0] read_ok
  // Result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [bsoc_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [6:0] charge_percent,
                                                             // [20:7] average_millivolts
  output logic                                   out_tuser,  // [0] sample_seen
  // Configuration writes
  input  logic                                   cfg_we,
  input  logic [bsoc_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [bsoc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import bsoc_pkg::*;

  logic [RATIO_W-1:0] divider_ratio_r;
  logic [SHIFT_W-1:0] smoothing_shift_r;

  bsoc_entry_t push_entry, pop_entry;
  logic        q_push, q_full, q_pop, q_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_ratio_r   <= RATIO_RESET;
      smoothing_shift_r <= SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DIVIDER_RATIO:   divider_ratio_r   <= cfg_wdata[RATIO_W-1:0];
        REG_SMOOTHING_SHIFT: smoothing_shift_r <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and scale
  bsoc_front u_front (
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .divider_ratio (divider_ratio_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  // Decoupling queue
  bsoc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  // Back end: average, interpolation, result register
  bsoc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .smoothing_shift (smoothing_shift_r),
    .q_valid         (q_valid),
    .q_entry         (pop_entry),
    .q_pop           (q_pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser)
  );

endmodule

[sv/bsoc_front.sv]
// ----------------------------------------------------------------------------
// bsoc_front
// Input side: accepts samples, applies the divider correction with saturation
// and hands a classified entry to the queue.
// ----------------------------------------------------------------------------
module bsoc_front (
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [bsoc_pkg::IN_TDATA_W-1:0]         in_tdata,   // [11:0] adc_millivolts
  input  logic                                    in_tuser,   // [0] read_ok
  input  logic [bsoc_pkg::RATIO_W-1:0]            divider_ratio,
  input  logic                                    q_full,
  output logic                                    q_push,
  output bsoc_pkg::bsoc_entry_t                   q_entry
);
  import bsoc_pkg::*;

  logic [ADC_W+RATIO_W-1:0] scaled;

  // Divider correction, clipped to the 14-bit range
  assign scaled = (ADC_W+RATIO_W)'(in_tdata[ADC_W-1:0]) * (ADC_W+RATIO_W)'(divider_ratio);

  always_comb begin
    q_entry.read_ok = in_tuser;
    if (scaled > (ADC_W+RATIO_W)'(MV_MAX)) begin
      q_entry.volt = MV_MAX;
    end else begin
      q_entry.volt = scaled[MV_W-1:0];
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

[sv/bsoc_queue.sv]
// ----------------------------------------------------------------------------
// bsoc_queue
// Small FIFO between front and back end so that each side stalls on its own.
// ----------------------------------------------------------------------------
module bsoc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bsoc_pkg::bsoc_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output bsoc_pkg::bsoc_entry_t pop_entry
);
  import bsoc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  bsoc_entry_t       slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_QW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[sv/bsoc_back.sv]
// ----------------------------------------------------------------------------
// bsoc_back
// Back end: moving-average update, curve segment lookup, serial divide for
// the interpolation, and the result register.
// ----------------------------------------------------------------------------
module bsoc_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [bsoc_pkg::SHIFT_W-1:0]          smoothing_shift,
  input  logic                                  q_valid,
  input  bsoc_pkg::bsoc_entry_t                 q_entry,
  output logic                                  q_pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [bsoc_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [6:0] charge_percent,
                                                            // [20:7] average_millivolts
  output logic                                  out_tuser   // [0] sample_seen
);
  import bsoc_pkg::*;

  bsoc_state_t state_r, state_nxt;

  // Estimator state
  logic [MV_W-1:0]   avg_r;
  logic              seeded_r;
  logic [PCT_W-1:0]  pct_r;

  // Divider
  logic [NUM_W-1:0]  num_r;
  logic [SPAN_W-1:0] den_r;
  logic [SPAN_W-1:0] rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [PCT_W-1:0]  base_r;
  logic [CNT_W-1:0]  cnt_r;

  // Result register
  logic              out_valid_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic [MV_W-1:0]   out_avg_r;
  logic              out_have_r;

  // Control decodes
  logic take_item, in_range, div_last, emit_load;

  // Moving-average step: avg + ((v - avg) >>> shift), floor shift
  logic signed [MV_W:0] diff;
  logic signed [MV_W:0] step;
  logic [MV_W:0]        avg_sum;
  logic [MV_W-1:0]      avg_new;

  assign diff    = $signed({1'b0, q_entry.volt}) - $signed({1'b0, avg_r});
  assign step    = diff >>> smoothing_shift;
  assign avg_sum = {1'b0, avg_r} + $unsigned(step);
  assign avg_new = seeded_r ? avg_sum[MV_W-1:0] : q_entry.volt;

  // Segment lookup: first segment whose lower end is at or below the average
  logic [SEG_W-1:0]   seg;
  logic               seg_found;
  logic [CMV_W-1:0]   seg_lo;
  logic [CMV_W-1:0]   seg_hi;
  logic [SPAN_W-1:0]  seg_span;
  logic [SPAN_W-1:0]  seg_off;
  logic [DP_W-1:0]    seg_dp;
  logic [CMV_W:0]     off_full;
  logic [PCT_W-1:0]   dp_full;

  always_comb begin
    seg       = '0;
    seg_found = 1'b0;
    for (int i = 0; i < CURVE_POINTS - 1; i++) begin
      if (!seg_found && (avg_r >= MV_W'(CURVE_MV[i+1]))) begin
        seg       = SEG_W'(i);
        seg_found = 1'b1;
      end
    end
  end

  always_comb begin
    seg_lo   = CURVE_MV[seg + 1'b1];
    seg_hi   = CURVE_MV[seg];
    seg_span = SPAN_W'(seg_hi - seg_lo);
    off_full = (CMV_W+1)'(avg_r) - (CMV_W+1)'(seg_lo);
    seg_off  = off_full[SPAN_W-1:0];
    dp_full  = CURVE_PCT[seg] - CURVE_PCT[seg + 1'b1];
    seg_dp   = dp_full[DP_W-1:0];
  end

  assign in_range = (avg_r < MV_W'(CURVE_MV[0])) &&
                    (avg_r > MV_W'(CURVE_MV[CURVE_POINTS-1]));

  // Restoring divide step
  logic [SPAN_W:0]   rem_sh;
  logic              rem_ge;
  logic [SPAN_W:0]   rem_sub;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = q_entry.read_ok ? B_LOOKUP : B_EMIT;
        end
      end
      B_LOOKUP: begin
        state_nxt = in_range ? B_DIV : B_EMIT;
      end
      B_DIV: begin
        if (div_last) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!out_valid_r) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    take_item = (state_r == B_IDLE) && q_valid;
    div_last  = (state_r == B_DIV) && (cnt_r == '0);
    emit_load = (state_r == B_EMIT) && !out_valid_r;
  end

  assign q_pop = take_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r    <= '0;
      seeded_r <= 1'b0;
      pct_r    <= '0;
    end else begin
      if (take_item && q_entry.read_ok) begin
        avg_r    <= avg_new;
        seeded_r <= 1'b1;
      end
      if (state_r == B_LOOKUP && !in_range) begin
        pct_r <= (avg_r >= MV_W'(CURVE_MV[0])) ? PCT_FULL : PCT_EMPTY;
      end
      // final quotient bit is resolved in this same cycle
      if (div_last) begin
        pct_r <= base_r + {quo_r[PCT_W-2:0], rem_ge};
      end
    end
  end

  // Interpolation datapath: (avg - lo) * dp / span, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (state_r == B_LOOKUP) begin
      num_r  <= NUM_W'(seg_off) * NUM_W'(seg_dp);
      den_r  <= seg_span;
      base_r <= CURVE_PCT[seg + 1'b1];
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= CNT_W'(NUM_W - 1);
    end else if (state_r == B_DIV) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (rem_ge) begin
        rem_r <= rem_sub[SPAN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[SPAN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_pct_r  <= pct_r;
      out_avg_r  <= avg_r;
      out_have_r <= seeded_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - MV_W - PCT_W)'(0), out_avg_r, out_pct_r};
  assign out_tuser  = out_have_r;

endmodule
